[hdl/plb_pkg.sv]
// Shared constants, types and helper functions of the pulse length bit decoder.
package plb_pkg;

    localparam int COUNT_WIDTH = 20;
    localparam int MAX_BYTES   = 64;

    localparam int CFG_W   = 20;
    localparam int TIME_W  = 20;
    localparam int KIND_W  = 3;
    localparam int PKTO_W  = 7;
    localparam int IDX_W   = 3;
    localparam int PKT_W   = $clog2(MAX_BYTES + 1);
    localparam int CMP_W   = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam int PCMP_W  = (PKT_W > PKTO_W) ? PKT_W : PKTO_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [TIME_W-1:0]      TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [PKTO_W-1:0]      PKTO_MAX  = {PKTO_W{1'b1}};
    localparam logic [PKT_W-1:0]       PKT_LIMIT = PKT_W'(MAX_BYTES);

    typedef enum logic [KIND_W-1:0] {
        EV_BIT     = 3'd0,
        EV_BYTE    = 3'd1,
        EV_RESET   = 3'd2,
        EV_BAD_PRE = 3'd3,
        EV_BAD_BIT = 3'd4
    } t_kind;

    typedef enum logic [IDX_W-1:0] {
        CFG_SHORT_MIN = 3'd0,
        CFG_SHORT_MAX = 3'd1,
        CFG_LONG_MIN  = 3'd2,
        CFG_LONG_MAX  = 3'd3,
        CFG_RESET_MIN = 3'd4,
        CFG_RESET_MAX = 3'd5,
        CFG_INVERT    = 3'd6,
        CFG_LOW_FIRST = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] short_min;
        logic [CFG_W-1:0] short_max;
        logic [CFG_W-1:0] long_min;
        logic [CFG_W-1:0] long_max;
        logic [CFG_W-1:0] reset_min;
        logic [CFG_W-1:0] reset_max;
        logic             invert_bits;
        logic             low_bit_first;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic              bit_value;
        logic [7:0]        byte_value;
        logic [PKTO_W-1:0] packet_bytes;
        logic [TIME_W-1:0] low_time;
        logic [TIME_W-1:0] high_time;
    } t_result;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic in_window(input logic [COUNT_WIDTH-1:0] t,
                                       input logic [CFG_W-1:0] lo,
                                       input logic [CFG_W-1:0] hi);
        logic [CMP_W-1:0] tv;
        tv = CMP_W'(t);
        return (tv > CMP_W'(lo)) && (tv < CMP_W'(hi));
    endfunction

    function automatic logic [TIME_W-1:0] clamp_time(input logic [COUNT_WIDTH-1:0] c);
        logic [CMP_W-1:0] v;
        v = CMP_W'(c);
        return (v > CMP_W'(TIME_MAX)) ? TIME_MAX : TIME_W'(v);
    endfunction

    function automatic logic [PKTO_W-1:0] clamp_pkt(input logic [PKT_W-1:0] p);
        logic [PCMP_W-1:0] v;
        v = PCMP_W'(p);
        return (v > PCMP_W'(PKTO_MAX)) ? PKTO_MAX : PKTO_W'(v);
    endfunction

endpackage

[hdl/plb_in_if.sv]
// Input channel carrying one line sample per item.
interface plb_in_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink (input valid, input line_level, output ready);
endinterface

[hdl/plb_out_if.sv]
// Output channel carrying one decoder event per item.
interface plb_out_if
    import plb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic              bit_value;
    logic [7:0]        byte_value;
    logic [PKTO_W-1:0] packet_bytes;
    logic [TIME_W-1:0] low_time;
    logic [TIME_W-1:0] high_time;

    modport source (output valid, output event_kind, output bit_value, output byte_value,
                    output packet_bytes, output low_time, output high_time, input ready);
    modport sink (input valid, input event_kind, input bit_value, input byte_value,
                  input packet_bytes, input low_time, input high_time, output ready);
endinterface

[hdl/plb_cfg.sv]
// Configuration register file of the pulse length bit decoder.
module plb_cfg
    import plb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_min     <= CFG_W'(90);
            r_cfg.short_max     <= CFG_W'(210);
            r_cfg.long_min      <= CFG_W'(390);
            r_cfg.long_max      <= CFG_W'(510);
            r_cfg.reset_min     <= CFG_W'(600);
            r_cfg.reset_max     <= CFG_W'(1200);
            r_cfg.invert_bits   <= 1'b0;
            r_cfg.low_bit_first <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SHORT_MIN: r_cfg.short_min     <= i_cfg_data;
                CFG_SHORT_MAX: r_cfg.short_max     <= i_cfg_data;
                CFG_LONG_MIN:  r_cfg.long_min      <= i_cfg_data;
                CFG_LONG_MAX:  r_cfg.long_max      <= i_cfg_data;
                CFG_RESET_MIN: r_cfg.reset_min     <= i_cfg_data;
                CFG_RESET_MAX: r_cfg.reset_max     <= i_cfg_data;
                CFG_INVERT:    r_cfg.invert_bits   <= i_cfg_data[0];
                CFG_LOW_FIRST: r_cfg.low_bit_first <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/plb_decode.sv]
// Edge timing state machine, bit classification and byte packing.
module plb_decode
    import plb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_level,
    input  t_cfg    i_cfg,
    output logic    o_res_valid,
    output t_result o_res
);

    typedef enum logic [2:0] {
        PH_WAIT_LOW  = 3'd0,
        PH_WAIT_RISE = 3'd1,
        PH_PREAMBLE  = 3'd2,
        PH_SYM_LOW   = 3'd3,
        PH_SYM_HIGH  = 3'd4
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic                   r_prev, n_prev;
    logic [COUNT_WIDTH-1:0] r_low_count, n_low_count;
    logic [COUNT_WIDTH-1:0] r_high_count, n_high_count;
    logic [3:0]             r_bits_held, n_bits_held;
    logic [7:0]             r_byte_shift, n_byte_shift;
    logic [PKT_W-1:0]       r_packet_count, n_packet_count;

    always_comb begin
        logic                   rise;
        logic                   fall;
        logic [COUNT_WIDTH-1:0] hc;
        logic                   one;
        logic                   zero;
        logic                   bit_v;
        logic [7:0]             sh;
        logic [3:0]             held;

        n_phase        = r_phase;
        n_prev         = r_prev;
        n_low_count    = r_low_count;
        n_high_count   = r_high_count;
        n_bits_held    = r_bits_held;
        n_byte_shift   = r_byte_shift;
        n_packet_count = r_packet_count;
        o_res_valid    = 1'b0;
        o_res          = '0;

        rise  = !r_prev && i_level;
        fall  = r_prev && !i_level;
        hc    = sat_inc(r_high_count);
        one   = in_window(r_low_count, i_cfg.short_min, i_cfg.short_max)
                && in_window(hc, i_cfg.long_min, i_cfg.long_max);
        zero  = in_window(hc, i_cfg.short_min, i_cfg.short_max)
                && in_window(r_low_count, i_cfg.long_min, i_cfg.long_max);
        bit_v = one ^ i_cfg.invert_bits;
        held  = r_bits_held + 4'd1;
        if (i_cfg.low_bit_first) begin
            sh = r_byte_shift | (8'(bit_v) << r_bits_held[2:0]);
        end else begin
            sh = {r_byte_shift[6:0], bit_v};
        end

        if (i_accept) begin
            n_prev = i_level;
            case (r_phase)
                PH_WAIT_LOW: begin
                    if (!i_level) begin
                        n_low_count = '0;
                        n_phase     = PH_WAIT_RISE;
                    end
                end
                PH_WAIT_RISE: begin
                    if (rise) begin
                        n_high_count = '0;
                        n_phase      = PH_PREAMBLE;
                    end
                end
                PH_PREAMBLE: begin
                    n_high_count = hc;
                    if (fall) begin
                        o_res_valid        = 1'b1;
                        o_res.packet_bytes = clamp_pkt(r_packet_count);
                        o_res.high_time    = clamp_time(hc);
                        n_packet_count     = '0;
                        n_bits_held        = '0;
                        n_byte_shift       = '0;
                        n_low_count        = '0;
                        if (in_window(hc, i_cfg.reset_min, i_cfg.reset_max)) begin
                            o_res.event_kind = EV_RESET;
                            n_phase          = PH_SYM_LOW;
                        end else begin
                            o_res.event_kind = EV_BAD_PRE;
                            n_phase          = PH_WAIT_RISE;
                        end
                    end
                end
                PH_SYM_LOW: begin
                    n_low_count = sat_inc(r_low_count);
                    if (rise) begin
                        n_high_count = '0;
                        n_phase      = PH_SYM_HIGH;
                    end
                end
                PH_SYM_HIGH: begin
                    n_high_count = hc;
                    if (fall) begin
                        o_res_valid    = 1'b1;
                        o_res.low_time  = clamp_time(r_low_count);
                        o_res.high_time = clamp_time(hc);
                        n_low_count    = '0;
                        if (one || zero) begin
                            o_res.bit_value = bit_v;
                            n_phase         = PH_SYM_LOW;
                            if (held[3]) begin
                                o_res.event_kind = EV_BYTE;
                                o_res.byte_value = sh;
                                n_bits_held      = '0;
                                n_byte_shift     = '0;
                                if (r_packet_count < PKT_LIMIT) begin
                                    n_packet_count = r_packet_count + 1'b1;
                                end
                            end else begin
                                o_res.event_kind = EV_BIT;
                                n_bits_held      = held;
                                n_byte_shift     = sh;
                            end
                        end else begin
                            o_res.packet_bytes = clamp_pkt(r_packet_count);
                            n_packet_count     = '0;
                            n_bits_held        = '0;
                            n_byte_shift       = '0;
                            if (in_window(hc, i_cfg.reset_min, i_cfg.reset_max)) begin
                                o_res.event_kind = EV_RESET;
                                n_phase          = PH_SYM_LOW;
                            end else begin
                                o_res.event_kind = EV_BAD_BIT;
                                n_phase          = PH_WAIT_RISE;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_WAIT_LOW;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_WAIT_LOW;
            r_prev         <= 1'b0;
            r_low_count    <= '0;
            r_high_count   <= '0;
            r_bits_held    <= '0;
            r_byte_shift   <= '0;
            r_packet_count <= '0;
        end else begin
            r_phase        <= n_phase;
            r_prev         <= n_prev;
            r_low_count    <= n_low_count;
            r_high_count   <= n_high_count;
            r_bits_held    <= n_bits_held;
            r_byte_shift   <= n_byte_shift;
            r_packet_count <= n_packet_count;
        end
    end

    a_event_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (i_accept && r_prev && !i_level))
        else $error("Event raised without a falling edge.");

    a_bad_bit_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.event_kind == EV_BAD_BIT)
        |=> (r_phase == PH_WAIT_RISE && r_packet_count == '0 && r_bits_held == '0))
        else $error("Bad bit did not return to idle with a cleared packet.");

    a_byte_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.event_kind == EV_BYTE)
        |=> (r_bits_held == '0 && r_byte_shift == '0 && r_phase == PH_SYM_LOW))
        else $error("Completed byte left bits behind.");

    a_bits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_held < 4'd8 && r_packet_count <= PKT_LIMIT)
        else $error("Bit or byte count out of range.");

endmodule

[hdl/pulse_length_bit_decoder.sv]
// Top level of the pulse length bit decoder: configuration, decoder and result register.
//
// One line sample enters per item on i_item; the block watches for a low
// level, a preamble high time inside the reset window, then decodes each
// low-then-high pulse pair into a bit and packs bits into bytes.
// Each item raises at most one event on o_result: a bit, a bit that
// completes a byte, a packet end, a bad preamble or a bad bit.
// An event is registered in the result register as the sample that causes
// it is accepted. Throughput is one sample per cycle while the result
// register can take an event, set by the single pass through the state
// register and the window compares.
// i_item.ready is high while the result register is empty or its held
// event is taken in the same cycle, and low while the receiver stalls it.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data,
// one register per cycle, and takes effect on the next sample.
// Synchronous reset clears the decoder state and loads the default
// windows; no memory needs clearing after reset.
module pulse_length_bit_decoder
    import plb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    plb_in_if.sink           i_item,
    plb_out_if.source        o_result,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    logic    accept;
    logic    res_valid;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    plb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    plb_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_level     (i_item.line_level),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.event_kind   = r_out.event_kind;
    assign o_result.bit_value    = r_out.bit_value;
    assign o_result.byte_value   = r_out.byte_value;
    assign o_result.packet_bytes = r_out.packet_bytes;
    assign o_result.low_time     = r_out.low_time;
    assign o_result.high_time    = r_out.high_time;

endmodule

[sim/tb_pulse_length_bit_decoder.sv]
// Self-checking testbench of the pulse length bit decoder with a built-in decoder predictor.
module tb_pulse_length_bit_decoder;
    import plb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [2:0] {
        ST_WAIT_LOW,
        ST_WAIT_RISE,
        ST_PREAMBLE,
        ST_SYM_LOW,
        ST_SYM_HIGH
    } t_line_state;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    plb_in_if  item_if ();
    plb_out_if result_if ();

    pulse_length_bit_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    logic    line_samples[$];
    t_result expected_events[$];
    int      samples_made = 0;
    int      mismatches = 0;
    int      stall_cycles = 0;
    logic    item_taken = 1'b0;
    logic    steady = 1'b0;

    // Predictor state and its copy of the configuration registers.
    t_cfg                   regs;
    t_line_state            line_state;
    logic                   prev_level;
    logic [COUNT_WIDTH-1:0] low_cnt;
    logic [COUNT_WIDTH-1:0] high_cnt;
    logic [3:0]             bits_held;
    logic [7:0]             shift_byte;
    logic [PKTO_W-1:0]      pkt_bytes;

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        return (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic logic in_span(input logic [COUNT_WIDTH-1:0] t,
                                     input logic [CFG_W-1:0] lo,
                                     input logic [CFG_W-1:0] hi);
        return (t > lo) && (t < hi);
    endfunction

    function automatic logic [PKTO_W-1:0] close_packet();
        logic [PKTO_W-1:0] n;
        n = pkt_bytes;
        pkt_bytes = '0;
        bits_held = '0;
        shift_byte = '0;
        return n;
    endfunction

    function automatic void decode_sample(input logic lvl);
        logic    rise;
        logic    fall;
        logic    one;
        logic    zero;
        logic    b;
        logic    fire;
        t_result ev;
        rise = !prev_level && lvl;
        fall = prev_level && !lvl;
        prev_level = lvl;
        fire = 1'b0;
        ev = '0;
        case (line_state)
            ST_WAIT_LOW: begin
                if (!lvl) begin
                    low_cnt = '0;
                    line_state = ST_WAIT_RISE;
                end
            end
            ST_WAIT_RISE: begin
                if (rise) begin
                    high_cnt = '0;
                    line_state = ST_PREAMBLE;
                end
            end
            ST_PREAMBLE: begin
                high_cnt = bump(high_cnt);
                if (fall) begin
                    one = in_span(high_cnt, regs.reset_min, regs.reset_max);
                    ev.event_kind = one ? EV_RESET : EV_BAD_PRE;
                    ev.packet_bytes = close_packet();
                    ev.high_time = TIME_W'(high_cnt);
                    line_state = one ? ST_SYM_LOW : ST_WAIT_RISE;
                    low_cnt = '0;
                    fire = 1'b1;
                end
            end
            ST_SYM_LOW: begin
                low_cnt = bump(low_cnt);
                if (rise) begin
                    high_cnt = '0;
                    line_state = ST_SYM_HIGH;
                end
            end
            ST_SYM_HIGH: begin
                high_cnt = bump(high_cnt);
                if (fall) begin
                    one = in_span(low_cnt, regs.short_min, regs.short_max)
                        && in_span(high_cnt, regs.long_min, regs.long_max);
                    zero = in_span(high_cnt, regs.short_min, regs.short_max)
                        && in_span(low_cnt, regs.long_min, regs.long_max);
                    ev.low_time = TIME_W'(low_cnt);
                    ev.high_time = TIME_W'(high_cnt);
                    if (one || zero) begin
                        b = one ^ regs.invert_bits;
                        if (regs.low_bit_first) begin
                            shift_byte = shift_byte | (8'(b) << bits_held[2:0]);
                        end else begin
                            shift_byte = {shift_byte[6:0], b};
                        end
                        bits_held = bits_held + 4'd1;
                        ev.bit_value = b;
                        if (bits_held >= 4'd8) begin
                            ev.event_kind = EV_BYTE;
                            ev.byte_value = shift_byte;
                            bits_held = '0;
                            shift_byte = '0;
                            if (pkt_bytes < MAX_BYTES) begin
                                pkt_bytes = pkt_bytes + 1'b1;
                            end
                        end else begin
                            ev.event_kind = EV_BIT;
                        end
                        line_state = ST_SYM_LOW;
                    end else if (in_span(high_cnt, regs.reset_min, regs.reset_max)) begin
                        ev.event_kind = EV_RESET;
                        ev.packet_bytes = close_packet();
                        line_state = ST_SYM_LOW;
                    end else begin
                        ev.event_kind = EV_BAD_BIT;
                        ev.packet_bytes = close_packet();
                        line_state = ST_WAIT_RISE;
                    end
                    low_cnt = '0;
                    fire = 1'b1;
                end
            end
            default: begin
                line_state = ST_WAIT_LOW;
            end
        endcase
        if (fire) begin
            expected_events.push_back(ev);
        end
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Input and output monitor, predictor feed and watchdog.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (result_if.valid && result_if.ready) begin
            if (expected_events.size() == 0) begin
                $error("event_kind: expected no item, got %0d", result_if.event_kind);
                mismatches++;
            end else begin
                want = expected_events.pop_front();
                compare_field("event_kind", want.event_kind, result_if.event_kind);
                compare_field("bit_value", want.bit_value, result_if.bit_value);
                compare_field("byte_value", want.byte_value, result_if.byte_value);
                compare_field("packet_bytes", want.packet_bytes, result_if.packet_bytes);
                compare_field("low_time", want.low_time, result_if.low_time);
                compare_field("high_time", want.high_time, result_if.high_time);
            end
        end
        if (item_if.valid && item_if.ready) begin
            decode_sample(item_if.line_level);
        end
        item_taken <= item_if.valid && item_if.ready;
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Sample driver and result back-pressure.
    always @(negedge i_clk) begin
        if (!item_if.valid || item_taken) begin
            if (line_samples.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
                item_if.valid <= 1'b1;
                item_if.line_level <= line_samples.pop_front();
            end else begin
                item_if.valid <= 1'b0;
            end
        end
        result_if.ready <= steady || ($urandom_range(99) >= 25);
    end

    task automatic add_run(input logic lvl, input int n);
        repeat (n) line_samples.push_back(lvl);
        samples_made += n;
    endtask

    task automatic add_pulse(input int lows, input int highs);
        add_run(1'b0, lows);
        add_run(1'b1, highs);
    endtask

    function automatic int pick_length(input int unsigned lo, input int unsigned hi,
                                       input bit loose);
        int unsigned top;
        if (loose && $urandom_range(4) == 0) begin
            if ($urandom_range(1) == 0 || hi > lo + 32) begin
                return (lo == 0) ? 1 : lo;
            end
            return hi;
        end
        if (hi <= lo + 1) begin
            return lo + 1;
        end
        top = (hi > lo + 17) ? lo + 16 : hi - 1;
        return $urandom_range(top, lo + 1);
    endfunction

    task automatic add_bit(input logic one_bit, input bit loose);
        if (one_bit) begin
            add_pulse(pick_length(regs.short_min, regs.short_max, loose),
                      pick_length(regs.long_min, regs.long_max, loose));
        end else begin
            add_pulse(pick_length(regs.long_min, regs.long_max, loose),
                      pick_length(regs.short_min, regs.short_max, loose));
        end
    endtask

    task automatic drain();
        while (line_samples.size() != 0 || item_if.valid || expected_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            CFG_SHORT_MIN: regs.short_min = val;
            CFG_SHORT_MAX: regs.short_max = val;
            CFG_LONG_MIN:  regs.long_min = val;
            CFG_LONG_MAX:  regs.long_max = val;
            CFG_RESET_MIN: regs.reset_min = val;
            CFG_RESET_MAX: regs.reset_max = val;
            CFG_INVERT:    regs.invert_bits = val[0];
            CFG_LOW_FIRST: regs.low_bit_first = val[0];
            default: ;
        endcase
    endtask

    task automatic load_windows(input int unsigned smin, input int unsigned smax,
                                input int unsigned lmin, input int unsigned lmax,
                                input int unsigned rmin, input int unsigned rmax,
                                input logic inv, input logic lsb);
        drain();
        set_reg(CFG_SHORT_MIN, CFG_W'(smin));
        set_reg(CFG_SHORT_MAX, CFG_W'(smax));
        set_reg(CFG_LONG_MIN, CFG_W'(lmin));
        set_reg(CFG_LONG_MAX, CFG_W'(lmax));
        set_reg(CFG_RESET_MIN, CFG_W'(rmin));
        set_reg(CFG_RESET_MAX, CFG_W'(rmax));
        set_reg(CFG_INVERT, {19'($urandom), inv});
        set_reg(CFG_LOW_FIRST, {19'($urandom), lsb});
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [7:0]  pattern;
        int unsigned smin;
        int unsigned smax;
        int unsigned lmin;
        int unsigned lmax;
        int unsigned rmin;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.line_level = 1'b0;
        result_if.ready = 1'b0;
        regs.short_min = 90;
        regs.short_max = 210;
        regs.long_min = 390;
        regs.long_max = 510;
        regs.reset_min = 600;
        regs.reset_max = 1200;
        regs.invert_bits = 1'b0;
        regs.low_bit_first = 1'b1;
        line_state = ST_WAIT_LOW;
        prev_level = 1'b0;
        low_cnt = '0;
        high_cnt = '0;
        bits_held = '0;
        shift_byte = '0;
        pkt_bytes = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default windows: high times far below the reset window are bad preambles.
        add_run(1'b1, 3);
        add_run(1'b0, 4);
        add_run(1'b1, 5);
        add_pulse(2, 5);
        add_run(1'b0, 2);

        load_windows(1, 4, 4, 8, 9, 14, 1'b0, 1'b1);
        add_pulse(1, 12);
        pattern = 8'hA5;
        for (int i = 0; i < 8; i++) begin
            if (pattern[i]) begin
                add_pulse(i % 2 ? 3 : 2, i % 2 ? 5 : 7);
            end else begin
                add_pulse(i % 2 ? 5 : 7, i % 2 ? 3 : 2);
            end
        end
        add_pulse(1, 13);
        add_pulse(3, 3);
        add_pulse(2, 9);
        add_pulse(2, 14);
        add_pulse(2, 10);
        repeat (3) add_bit(1'($urandom_range(1)), 1'b0);
        add_pulse(4, 12);
        add_pulse(1, 8);
        add_pulse(2, 13);
        add_run(1'b0, 2);

        load_windows(1, 4, 4, 8, 9, 14, 1'b1, 1'b0);
        pattern = 8'h3C;
        for (int i = 7; i >= 0; i--) begin
            add_bit(pattern[i], 1'b0);
        end
        add_pulse(2, 11);
        add_run(1'b0, 2);

        // Tightest windows so that the packet byte count reaches its ceiling.
        load_windows(0, 2, 0, 2, 2, 4, 1'($urandom_range(1)), 1'b1);
        steady = 1'b1;
        add_pulse(1, 3);
        repeat (65 * 8) add_pulse(1, 1);
        add_pulse(1, 3);
        add_pulse(1, 3);
        add_run(1'b0, 2);

        for (int p = 0; p < 3; p++) begin
            if (p == 2) begin
                load_windows(0, 4, 4, 9, 10, 20'hFFFFF,
                             1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                smin = $urandom_range(3);
                smax = smin + $urandom_range(5, 2);
                lmin = smax + $urandom_range(2) - 1;
                lmax = lmin + $urandom_range(6, 2);
                rmin = lmax + $urandom_range(2);
                load_windows(smin, smax, lmin, lmax, rmin, rmin + $urandom_range(8, 2),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            steady = 1'b0;
            smin = samples_made;
            while (samples_made - smin < 20) begin
                lmin = $urandom_range(99);
                if (lmin < 70) begin
                    add_pulse($urandom_range(6, 1),
                              pick_length(regs.reset_min, regs.reset_max, 1'b0));
                    repeat ($urandom_range(6, 1)) add_bit(1'($urandom_range(1)), 1'b0);
                    if ($urandom_range(3) != 0) begin
                        add_pulse($urandom_range(6, 1),
                                  pick_length(regs.reset_min, regs.reset_max, 1'b0));
                    end
                end else if (lmin < 88) begin
                    add_pulse($urandom_range(6, 1),
                              pick_length(regs.reset_min, regs.reset_max, 1'b1));
                    repeat ($urandom_range(6, 1)) add_bit(1'($urandom_range(1)), 1'b1);
                end else begin
                    repeat ($urandom_range(4, 1)) begin
                        add_pulse($urandom_range(20, 1), $urandom_range(20, 1));
                    end
                end
            end
            add_run(1'b0, 2);
        end
        drain();
        steady = 1'b0;

        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/plb_pkg.sv
hdl/plb_in_if.sv
hdl/plb_out_if.sv
hdl/plb_cfg.sv
hdl/plb_decode.sv
hdl/pulse_length_bit_decoder.sv
sim/tb_pulse_length_bit_decoder.sv
